[rtl/core/shell_word_tokenizer_top_defines.svh]
// assertion macros shared by the shell word tokenizer checkers
// expects clk and rst_n in the scope where a macro is used
`ifndef SHELL_WORD_TOKENIZER_TOP_DEFINES_SVH
`define SHELL_WORD_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, held off while in reset
`define SWT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define SWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/swt_pkg.sv]
// shared types, character codes and result kinds of the shell word tokenizer
// no dependencies
package swt_pkg;

  localparam int unsigned TOKEN_COUNT_MAX = 255;
  localparam logic [7:0]  COUNT_LIMIT     =
    (TOKEN_COUNT_MAX > 255) ? 8'd255 : 8'(TOKEN_COUNT_MAX);

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_EOT  = 2'd1;
  localparam logic [1:0] KIND_EOL  = 2'd2;

  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_valid;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic [7:0] token_count;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] items;
    logic [RES_CNT_W-1:0]      count;
  } bundle_t;

  function automatic logic dq_escapable(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_BACKSLASH) || (c == CH_DOLLAR) ||
           (c == CH_NEWLINE);
  endfunction

endpackage

[rtl/core/swt_ifs.sv]
// valid/ready channel interfaces for command line bytes and tokenizer results
// no dependencies
interface swt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_valid;
  logic       end_of_line;

  modport source (output valid, in_byte, byte_valid, end_of_line, input ready);
  modport sink   (input valid, in_byte, byte_valid, end_of_line, output ready);
endinterface

interface swt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [7:0] token_count;
  logic       last_of_run;

  modport source (output valid, kind, out_char, token_count, last_of_run, input ready);
  modport sink   (input valid, kind, out_char, token_count, last_of_run, output ready);
endinterface

[rtl/core/swt_lexer.sv]
// input register, quote/escape state and per-byte decode into a result bundle
// depends on swt_pkg and swt_in_if
module swt_lexer (
  input  logic            clk,
  input  logic            rst_n,
  swt_in_if.sink          in_ch,
  input  logic            bnd_free,
  output logic            bnd_load,
  output swt_pkg::bundle_t bnd
);

  logic               in_vld_r, in_vld_nxt;
  swt_pkg::in_item_t  in_item_r;

  logic [1:0] quote_r, quote_nxt;
  logic       esc_r, esc_nxt;
  logic       open_r, open_nxt;
  logic [7:0] seen_r, seen_nxt;

  logic in_xfer;

  assign in_ch.ready = !in_vld_r || bnd_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign bnd_load    = in_vld_r && bnd_free;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) begin
      in_vld_nxt = 1'b1;
    end else if (bnd_load) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
    if (in_xfer) begin
      in_item_r.in_byte     <= in_ch.in_byte;
      in_item_r.byte_valid  <= in_ch.byte_valid;
      in_item_r.end_of_line <= in_ch.end_of_line;
    end
  end

  // decode of one item, following the order in which results are produced
  always_comb begin
    logic [1:0]                        q_v;
    logic                              esc_v;
    logic                              open_v;
    logic [7:0]                        cnt_v;
    logic [swt_pkg::RES_CNT_W-1:0]     n_v;
    swt_pkg::result_t [swt_pkg::MAX_RESULTS-1:0] it_v;
    logic [7:0]                        c;
    logic                              vld;
    logic                              inq;
    logic                              isq;
    logic [1:0]                        mode;
    logic                              dq_lit;
    logic                              bs_first;
    logic                              raw_c;
    logic                              do_plain;

    q_v    = quote_r;
    esc_v  = esc_r;
    open_v = open_r;
    cnt_v  = seen_r;
    n_v    = '0;
    it_v   = '0;
    c      = in_item_r.in_byte;
    vld    = in_item_r.byte_valid;

    dq_lit   = (quote_r == swt_pkg::QM_DOUBLE) && !swt_pkg::dq_escapable(c);
    bs_first = vld && esc_r && dq_lit;
    raw_c    = vld && esc_r && !dq_lit;
    do_plain = vld && (esc_r ? dq_lit
                             : !((c == swt_pkg::CH_BACKSLASH) &&
                                 (quote_r != swt_pkg::QM_SINGLE)));

    inq  = (quote_r == swt_pkg::QM_SINGLE) || (quote_r == swt_pkg::QM_DOUBLE);
    isq  = (c == swt_pkg::CH_SQUOTE) || (c == swt_pkg::CH_DQUOTE);
    mode = (c == swt_pkg::CH_SQUOTE) ? swt_pkg::QM_SINGLE : swt_pkg::QM_DOUBLE;

    if (vld) begin
      if (esc_r) begin
        esc_v = 1'b0;
      end else if ((c == swt_pkg::CH_BACKSLASH) && (quote_r != swt_pkg::QM_SINGLE)) begin
        esc_v = 1'b1;
      end
    end

    // backslash kept literal inside double quotes
    if (bs_first) begin
      it_v[n_v[1:0]].kind     = swt_pkg::KIND_CHAR;
      it_v[n_v[1:0]].out_char = swt_pkg::CH_BACKSLASH;
      n_v    = n_v + 1'b1;
      open_v = 1'b1;
    end
    if (raw_c) begin
      it_v[n_v[1:0]].kind     = swt_pkg::KIND_CHAR;
      it_v[n_v[1:0]].out_char = c;
      n_v    = n_v + 1'b1;
      open_v = 1'b1;
    end

    if (do_plain) begin
      if (isq && !inq) begin
        q_v = mode;
      end else if (isq && (q_v == mode)) begin
        q_v = swt_pkg::QM_NONE;
      end else if ((c == swt_pkg::CH_SPACE) && !inq) begin
        if (open_v) begin
          it_v[n_v[1:0]].kind = swt_pkg::KIND_EOT;
          n_v    = n_v + 1'b1;
          open_v = 1'b0;
          if (cnt_v < swt_pkg::COUNT_LIMIT) begin
            cnt_v = cnt_v + 8'd1;
          end
        end
      end else begin
        it_v[n_v[1:0]].kind     = swt_pkg::KIND_CHAR;
        it_v[n_v[1:0]].out_char = c;
        n_v    = n_v + 1'b1;
        open_v = 1'b1;
      end
    end

    if (in_item_r.end_of_line) begin
      // a backslash left hanging at end of line is a literal
      if (esc_v) begin
        it_v[n_v[1:0]].kind     = swt_pkg::KIND_CHAR;
        it_v[n_v[1:0]].out_char = swt_pkg::CH_BACKSLASH;
        n_v    = n_v + 1'b1;
        open_v = 1'b1;
      end
      if (open_v) begin
        it_v[n_v[1:0]].kind = swt_pkg::KIND_EOT;
        n_v = n_v + 1'b1;
        if (cnt_v < swt_pkg::COUNT_LIMIT) begin
          cnt_v = cnt_v + 8'd1;
        end
      end
      it_v[n_v[1:0]].kind        = swt_pkg::KIND_EOL;
      it_v[n_v[1:0]].token_count = cnt_v;
      n_v    = n_v + 1'b1;
      q_v    = swt_pkg::QM_NONE;
      esc_v  = 1'b0;
      open_v = 1'b0;
      cnt_v  = 8'd0;
    end

    bnd.items = it_v;
    bnd.count = n_v;
    quote_nxt = q_v;
    esc_nxt   = esc_v;
    open_nxt  = open_v;
    seen_nxt  = cnt_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_r <= swt_pkg::QM_NONE;
      esc_r   <= 1'b0;
      open_r  <= 1'b0;
      seen_r  <= 8'd0;
    end else if (bnd_load) begin
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      open_r  <= open_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[rtl/core/swt_emit.sv]
// result register: holds one bundle and hands it out one result per transfer
// depends on swt_pkg and swt_out_if
module swt_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             bnd_load,
  input  swt_pkg::bundle_t bnd,
  output logic             bnd_free,
  swt_out_if.source        out_ch
);

  swt_pkg::result_t [swt_pkg::MAX_RESULTS-1:0] items_r;
  logic [swt_pkg::RES_CNT_W-1:0]               cnt_r, cnt_nxt;

  logic out_xfer;

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.kind        = items_r[0].kind;
  assign out_ch.out_char    = items_r[0].out_char;
  assign out_ch.token_count = items_r[0].token_count;
  assign out_ch.last_of_run = (cnt_r == swt_pkg::RES_CNT_W'(1));

  assign out_xfer = out_ch.valid && out_ch.ready;
  // free once the last pending result leaves this cycle
  assign bnd_free = (cnt_r == '0) || (out_ch.last_of_run && out_ch.ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (bnd_load) begin
      cnt_nxt = bnd.count;
    end else if (out_xfer) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (bnd_load) begin
      items_r <= bnd.items;
    end else if (out_xfer) begin
      for (int i = 0; i < swt_pkg::MAX_RESULTS - 1; i++) begin
        items_r[i] <= items_r[i+1];
      end
    end
  end

endmodule

[rtl/core/shell_word_tokenizer_top.sv]
// Shell word tokenizer: splits a command line, one byte per input transfer, into
// words with single/double quotes and backslash escapes, emitting word characters,
// end-of-word marks and an end-of-line mark with the word count. A byte is taken
// every cycle while each byte yields one result and the output is ready; it passes
// an input register, is decoded combinationally into up to four results, and those
// leave the result register one per cycle while the output is ready. A multi-result
// item holds the result register until its last result has left and one that yields
// none does not occupy it, so the input stalls while a multi-result item drains or
// while the output holds off. Each byte passes the input then the result register.
// depends on swt_pkg, swt_ifs, swt_lexer, swt_emit
module shell_word_tokenizer_top (
  input  logic      clk,
  input  logic      rst_n,
  swt_in_if.sink    in_ch,
  swt_out_if.source out_ch
);

  logic             bnd_free;
  logic             bnd_load;
  swt_pkg::bundle_t bnd;

  swt_lexer u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .bnd_free (bnd_free),
    .bnd_load (bnd_load),
    .bnd      (bnd)
  );

  swt_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .bnd_load (bnd_load),
    .bnd      (bnd),
    .bnd_free (bnd_free),
    .out_ch   (out_ch)
  );

endmodule

[rtl/core/swt_checker.sv]
// port-level checks on the tokenizer result channel, bound to the top level
// depends on swt_pkg and shell_word_tokenizer_top_defines.svh
`include "shell_word_tokenizer_top_defines.svh"

module swt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_char,
  input logic [7:0] token_count,
  input logic       last_of_run
);

  `SWT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(out_char) && $stable(token_count) && $stable(last_of_run), "result changed while stalled")
  `SWT_ASSERT_IMPLIES(a_eol_last, out_valid && (kind == swt_pkg::KIND_EOL), last_of_run, "end of line not last of run")
  `SWT_ASSERT_IMPLIES(a_char_zero, out_valid && (kind != swt_pkg::KIND_CHAR), out_char == 8'd0, "character on a mark")
  `SWT_ASSERT_IMPLIES(a_count_zero, out_valid && (kind != swt_pkg::KIND_EOL), token_count == 8'd0, "count outside end of line")

endmodule

bind shell_word_tokenizer_top swt_checker u_swt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .out_char    (out_ch.out_char),
  .token_count (out_ch.token_count),
  .last_of_run (out_ch.last_of_run)
);

[tb/sv/swt_token_checker.sv]
// shell word tokenizer checker: watches the byte and result channels, predicts
// the words that each accepted byte yields and compares them with the block's output
// depends on swt_pkg and swt_ifs
module swt_token_checker
  import swt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  swt_in_if           in_ch,
  swt_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned outstanding,
  output int unsigned results_checked,
  output int unsigned lines_checked,
  output int unsigned saturated_lines
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [7:0] count;
    logic       last;
  } token_out_t;

  token_out_t  expected_tokens[$];
  token_out_t  item_out[$];

  logic [1:0]  quote_mode_m;
  logic        escape_pending_m;
  logic        word_open;
  logic [7:0]  words_closed;

  int unsigned mismatches;
  int unsigned results_n;
  int unsigned lines_n;
  int unsigned sat_n;

  function automatic bit quoted();
    return (quote_mode_m == QM_SINGLE) || (quote_mode_m == QM_DOUBLE);
  endfunction

  task automatic put_result(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [7:0] cnt);
    token_out_t t;
    t.kind  = kind;
    t.ch    = ch;
    t.count = cnt;
    t.last  = 1'b0;
    item_out.push_back(t);
  endtask

  task automatic put_word_char(input logic [7:0] ch);
    put_result(KIND_CHAR, ch, 8'd0);
    word_open = 1'b1;
  endtask

  task automatic close_word();
    if (word_open) begin
      put_result(KIND_EOT, 8'd0, 8'd0);
      if (words_closed < COUNT_LIMIT) words_closed = words_closed + 8'd1;
      word_open = 1'b0;
    end
  endtask

  task automatic handle_plain(input logic [7:0] c);
    logic [1:0] mode;
    mode = (c == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      if (!quoted()) begin
        quote_mode_m = mode;
        return;
      end
      // the other quote character falls through as a word character
      if (quote_mode_m == mode) begin
        quote_mode_m = QM_NONE;
        return;
      end
    end
    if (c == CH_SPACE && !quoted()) close_word();
    else put_word_char(c);
  endtask

  task automatic clear_line_state();
    quote_mode_m     = QM_NONE;
    escape_pending_m = 1'b0;
    word_open        = 1'b0;
    words_closed     = 8'd0;
  endtask

  task automatic split_words(input logic [7:0] c, input logic bv, input logic eol);
    item_out.delete();
    if (bv) begin
      if (escape_pending_m) begin
        escape_pending_m = 1'b0;
        // inside double quotes only four bytes can be escaped
        if (quote_mode_m == QM_DOUBLE &&
            !(c inside {CH_DQUOTE, CH_BACKSLASH, CH_DOLLAR, CH_NEWLINE})) begin
          put_word_char(CH_BACKSLASH);
          handle_plain(c);
        end else begin
          put_word_char(c);
        end
      end else if (c == CH_BACKSLASH && quote_mode_m != QM_SINGLE) begin
        escape_pending_m = 1'b1;
      end else begin
        handle_plain(c);
      end
    end
    if (eol) begin
      if (escape_pending_m) put_word_char(CH_BACKSLASH);
      close_word();
      put_result(KIND_EOL, 8'd0, words_closed);
      lines_n++;
      if (words_closed == COUNT_LIMIT) sat_n++;
      clear_line_state();
    end
    if (item_out.size() > 0) item_out[item_out.size() - 1].last = 1'b1;
    foreach (item_out[i]) expected_tokens.push_back(item_out[i]);
  endtask

  always @(posedge clk) begin : watch
    token_out_t got;
    token_out_t want;
    if (!rst_n) begin
      expected_tokens.delete();
      clear_line_state();
      mismatches = 0;
      results_n  = 0;
      lines_n    = 0;
      sat_n      = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        split_words(in_ch.in_byte, in_ch.byte_valid, in_ch.end_of_line);
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.kind, out_ch.out_char, out_ch.token_count, out_ch.last_of_run};
        if (expected_tokens.size() == 0) begin
          if (mismatches < 10)
            $display("[%0t] unexpected result: kind %0d char %02h count %0d last %0b",
                     $realtime, got.kind, got.ch, got.count, got.last);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          results_n++;
          if (got.kind !== want.kind || got.ch !== want.ch ||
              got.count !== want.count || got.last !== want.last) begin
            if (mismatches < 10)
              $display({"[%0t] result mismatch: expected kind %0d char %02h count %0d",
                        " last %0b, got kind %0d char %02h count %0d last %0b"},
                       $realtime, want.kind, want.ch, want.count, want.last,
                       got.kind, got.ch, got.count, got.last);
            mismatches++;
          end
        end
      end
    end
    fail_count      <= mismatches;
    outstanding     <= expected_tokens.size();
    results_checked <= results_n;
    lines_checked   <= lines_n;
    saturated_lines <= sat_n;
  end

endmodule

[tb/sv/testbench.sv]
// top of the shell word tokenizer regression: clock, reset, byte stimulus,
// result back-pressure and the verdict; checking sits in swt_token_checker
// depends on swt_pkg, swt_ifs, shell_word_tokenizer_top and swt_token_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import swt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 84;
  localparam int unsigned HOLD_CYCLES = 250;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  swt_in_if  in_ch();
  swt_out_if out_ch();

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned lines_checked;
  int unsigned saturated_lines;

  shell_word_tokenizer_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  swt_token_checker u_token_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .lines_checked   (lines_checked),
    .saturated_lines (saturated_lines)
  );

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests  = 0;
  int unsigned holds_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned items_sent     = 0;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("shell_word_tokenizer_top regression: fail");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_requests > holds_served) begin
      out_ch.ready <= 1'b0;
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic bv, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.byte_valid  <= bv;
    in_ch.end_of_line <= eol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (bv || eol) items_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // weighted toward the characters that steer the tokenizer
  function automatic logic [7:0] pick_char();
    case ($urandom_range(15))
      0, 1:    return CH_SPACE;
      2:       return CH_SQUOTE;
      3:       return CH_DQUOTE;
      4, 5:    return CH_BACKSLASH;
      6:       return CH_DOLLAR;
      7:       return CH_NEWLINE;
      8:       return 8'($urandom_range(255));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic send_line(input bit garbled);
    int unsigned len;
    bit          bare_end;
    logic [7:0]  c;
    len      = $urandom_range(16);
    bare_end = (len == 0) || ($urandom_range(4) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(29) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      c = garbled ? 8'($urandom) : pick_char();
      send_item(c, 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start          = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_line($urandom_range(6) == 0);
  endtask

  task automatic directed_part();
    send_item(8'h00, 1'b1, 1'b0);          // zero byte is a plain character
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);       // repeated space closes nothing
    send_item(CH_DQUOTE, 1'b1, 1'b0);
    send_item(CH_DQUOTE, 1'b1, 1'b0);      // empty quotes
    send_item(CH_BACKSLASH, 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);       // escaped space
    send_item(CH_DQUOTE, 1'b1, 1'b0);
    send_item(CH_BACKSLASH, 1'b1, 1'b0);
    send_item(CH_DOLLAR, 1'b1, 1'b0);
    send_item(CH_BACKSLASH, 1'b1, 1'b0);
    send_item("q", 1'b1, 1'b0);            // backslash kept before q
    send_item(CH_SQUOTE, 1'b1, 1'b0);
    send_item(CH_DQUOTE, 1'b1, 1'b0);
    send_item(CH_SQUOTE, 1'b1, 1'b0);
    send_item(CH_BACKSLASH, 1'b1, 1'b0);   // literal inside single quotes
    send_item(CH_DQUOTE, 1'b1, 1'b0);
    send_item(CH_SPACE, 1'b1, 1'b0);
    send_item(CH_BACKSLASH, 1'b1, 1'b1);   // line ends with quote still open
    send_item(CH_BACKSLASH, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);          // trailing backslash
    send_item(8'hA5, 1'b0, 1'b0);          // ignored item
    send_item(8'h5A, 1'b0, 1'b1);          // empty line
    send_item(CH_DQUOTE, 1'b1, 1'b0);
    send_item(CH_BACKSLASH, 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b1);            // four results from one transfer
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'd0;
    in_ch.byte_valid  <= 1'b0;
    in_ch.end_of_line <= 1'b0;
    while (!rst_n) @(posedge clk);
    @(posedge clk);

    directed_part();
    wait_drained();

    run_phase(0, 0);
    run_phase(54, 0);
    // sender holds back until every result is out
    wait_drained();
    run_phase(0, 54);
    run_phase(10, 10);

    // long receiver hold-off while bytes keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int i = 0; i < 40; i++) send_item(pick_char(), 1'b1, i == 39);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("stimulus: %0d byte/eol transfers over %0d command lines, %0d results checked",
             items_sent, lines_checked, results_checked);
    $display("idle and stall mixes, long output hold-off, %0d saturated count line(s)",
             saturated_lines);
    if (fail_count == 0 && outstanding == 0) begin
      $display("shell_word_tokenizer_top regression: pass");
    end else begin
      $display("shell_word_tokenizer_top regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/swt_pkg.sv
rtl/core/swt_ifs.sv
rtl/core/swt_lexer.sv
rtl/core/swt_emit.sv
rtl/core/shell_word_tokenizer_top.sv
rtl/core/swt_checker.sv
tb/sv/swt_token_checker.sv
tb/sv/testbench.sv
